// File: design/uuidg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID generator package
// Shared types, constants and helper functions for the version-4 UUID text
// generator: the xorshift128+ mixing step and the character pattern.
// ----------------------------------------------------------------------------
`default_nettype none

package uuidg_pkg;

  // Text geometry.
  localparam int unsigned UuidLen = 36;
  localparam logic [5:0]  LastPos = 6'd35;

  // Fixed characters of the pattern.
  localparam logic [7:0] CharDash = 8'h2d;
  localparam logic [7:0] CharFour = 8'h34;

  // Character positions with a fixed or special meaning.
  localparam logic [5:0] PosDash0   = 6'd8;
  localparam logic [5:0] PosDash1   = 6'd13;
  localparam logic [5:0] PosFour    = 6'd14;
  localparam logic [5:0] PosDash2   = 6'd18;
  localparam logic [5:0] PosVariant = 6'd19;
  localparam logic [5:0] PosDash3   = 6'd23;

  // Generator shift amounts.
  localparam int unsigned ShiftA = 23;
  localparam int unsigned ShiftB = 18;
  localparam int unsigned ShiftC = 5;

  // Kind of character at a text position.
  typedef enum logic [1:0] {
    KIND_HEX,
    KIND_VARIANT,
    KIND_DASH,
    KIND_FOUR
  } uuidg_kind_e;

  // Front-end sequencer states.
  typedef enum logic [1:0] {
    FRONT_IDLE,
    FRONT_DRAW_LO,
    FRONT_DRAW_HI,
    FRONT_PUSH
  } uuidg_front_e;

  // Two drawn words queued between front and back end.
  typedef struct packed {
    logic [63:0] word_hi;
    logic [63:0] word_lo;
  } uuidg_draw_t;

  // Handshake bundle from the front end into the queue.
  typedef struct packed {
    logic        valid;
    uuidg_draw_t data;
  } uuidg_push_t;

  // New second state word of one xorshift128+ step.
  function automatic logic [63:0] uuidg_mix(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] x;
    x = a ^ (a << ShiftA);
    return x ^ b ^ (x >> ShiftB) ^ (b >> ShiftC);
  endfunction

  // Classify a text position.
  function automatic uuidg_kind_e uuidg_kind(input logic [5:0] pos);
    uuidg_kind_e k;
    case (pos)
      PosDash0, PosDash1, PosDash2, PosDash3: k = KIND_DASH;
      PosFour:                                k = KIND_FOUR;
      PosVariant:                             k = KIND_VARIANT;
      default:                                k = KIND_HEX;
    endcase
    return k;
  endfunction

  // Lower-case ASCII hex digit of a nibble.
  function automatic logic [7:0] uuidg_hex(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h57 + {4'h0, n});
  endfunction

endpackage

`default_nettype wire

// File: design/uuidg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID generator front end
// Accepts requests, optionally reseeds the xorshift128+ state and draws two
// 64-bit words, one per cycle, then pushes the pair into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module uuidg_front import uuidg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        reseed_i,
  input  wire logic [63:0] seed_first_i,
  input  wire logic [63:0] seed_second_i,
  output uuidg_push_t      push_o,
  input  wire logic        push_ready_i
);

  uuidg_front_e state_q, state_d;
  logic [63:0]  gen_a_q, gen_a_d;
  logic [63:0]  gen_b_q, gen_b_d;
  logic [63:0]  word_lo_q, word_lo_d;
  logic [63:0]  word_hi_q, word_hi_d;
  logic [63:0]  mix_b;
  logic [63:0]  drawn;
  logic         accept;

  // One generator step on the current state.
  assign mix_b = uuidg_mix(gen_a_q, gen_b_q);
  assign drawn = mix_b + gen_b_q;

  // A new transaction is taken when idle or while the finished pair leaves.
  assign in_ready_o = (state_q == FRONT_IDLE) ||
                      ((state_q == FRONT_PUSH) && push_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      FRONT_IDLE: begin
        if (accept) state_d = FRONT_DRAW_LO;
      end
      FRONT_DRAW_LO: state_d = FRONT_DRAW_HI;
      FRONT_DRAW_HI: state_d = FRONT_PUSH;
      FRONT_PUSH: begin
        if (push_ready_i) state_d = accept ? FRONT_DRAW_LO : FRONT_IDLE;
      end
      default: state_d = FRONT_IDLE;
    endcase
  end

  // Generator state, drawn words and queue push.
  always_comb begin
    gen_a_d   = gen_a_q;
    gen_b_d   = gen_b_q;
    word_lo_d = word_lo_q;
    word_hi_d = word_hi_q;
    push_o.valid        = 1'b0;
    push_o.data.word_lo = word_lo_q;
    push_o.data.word_hi = word_hi_q;
    case (state_q)
      FRONT_DRAW_LO: begin
        gen_a_d   = gen_b_q;
        gen_b_d   = mix_b;
        word_lo_d = drawn;
      end
      FRONT_DRAW_HI: begin
        gen_a_d   = gen_b_q;
        gen_b_d   = mix_b;
        word_hi_d = drawn;
      end
      FRONT_PUSH: begin
        push_o.valid = 1'b1;
      end
      default: begin
      end
    endcase
    if (accept && reseed_i) begin
      gen_a_d = seed_first_i;
      gen_b_d = seed_second_i;
    end
  end

  // Control and generator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FRONT_IDLE;
      gen_a_q <= '0;
      gen_b_q <= '0;
    end else begin
      state_q <= state_d;
      gen_a_q <= gen_a_d;
      gen_b_q <= gen_b_d;
    end
  end

  // Drawn words.
  always_ff @(posedge clk_i) begin
    word_lo_q <= word_lo_d;
    word_hi_q <= word_hi_d;
  end

endmodule

`default_nettype wire

// File: design/uuidg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID generator queue
// Short register queue carrying drawn word pairs from the front end to the
// back end so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module uuidg_queue import uuidg_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire uuidg_push_t push_i,
  output logic        push_ready_o,
  output logic        pop_valid_o,
  output uuidg_draw_t pop_data_o,
  input  wire logic   pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  uuidg_draw_t     entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i.valid && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

`default_nettype wire

// File: design/uuidg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID generator back end
// Takes a word pair from the queue and emits the 36 characters of the UUID
// text through a registered output stage, one per cycle when not stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module uuidg_back import uuidg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        pop_valid_i,
  input  wire uuidg_draw_t pop_data_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       text_char_o,
  output logic [5:0]       char_index_o,
  output logic             last_char_o
);

  logic [127:0] words_q;
  logic [5:0]   pos_q;
  logic [4:0]   nib_q;
  logic         active_q;
  logic         out_valid_q;
  logic [7:0]   char_q;
  logic [5:0]   index_q;
  logic         last_q;

  logic         load_out;
  logic         at_last;
  logic [3:0]   nibble;
  uuidg_kind_e  kind;
  logic [7:0]   char_d;

  assign at_last  = (pos_q == LastPos);
  assign load_out = active_q && (!out_valid_q || out_ready_i);
  assign pop_o    = pop_valid_i && (!active_q || (load_out && at_last));

  // Current character.
  assign nibble = words_q[{nib_q, 2'b00} +: 4];
  assign kind   = uuidg_kind(pos_q);

  always_comb begin
    case (kind)
      KIND_DASH:    char_d = CharDash;
      KIND_FOUR:    char_d = CharFour;
      KIND_VARIANT: char_d = uuidg_hex({2'b10, nibble[1:0]});
      default:      char_d = uuidg_hex(nibble);
    endcase
  end

  // Sequencing of positions and the output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      nib_q       <= '0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        active_q <= 1'b1;
        pos_q    <= '0;
        nib_q    <= '0;
      end else if (load_out) begin
        if (at_last) begin
          active_q <= 1'b0;
        end
        pos_q <= pos_q + 1'b1;
        if ((kind == KIND_HEX) || (kind == KIND_VARIANT)) begin
          nib_q <= nib_q + 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      words_q <= {pop_data_i.word_hi, pop_data_i.word_lo};
    end
    if (load_out) begin
      char_q  <= char_d;
      index_q <= pos_q;
      last_q  <= at_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign text_char_o  = char_q;
  assign char_index_o = index_q;
  assign last_char_o  = last_q;

endmodule

`default_nettype wire

// File: design/uuid_v4_text_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Version-4 UUID text generator
// Top level: front end, word-pair queue and character back end.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction on the input channel requests one UUID. With reseed_i high
//   the two seed words are loaded into the xorshift128+ state first; then two
//   64-bit words are drawn. The output channel carries the 36 ASCII characters
//   of the text, one per transaction, with char_index_o and last_char_o.
//   After a request is accepted, the two words are drawn, the pair is pushed
//   into the queue, the back end loads it and the first character goes into
//   the output register, from which it is shown.
//   Throughput is set by the output channel: one character per cycle while
//   the receiver does not stall. The front end runs ahead while the back end
//   is still emitting.
//   Reset clears the generator state to zero (it then yields zeros until
//   seeded), empties the queue and drops any partly sent text.
//   When the receiver stalls, the current character holds in the output
//   register; the queue fills, and then the input channel stops accepting.
// ----------------------------------------------------------------------------
`default_nettype none

module uuid_v4_text_generator import uuidg_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        reseed_i,
  input  wire logic [63:0] seed_first_i,
  input  wire logic [63:0] seed_second_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       text_char_o,
  output logic [5:0]       char_index_o,
  output logic             last_char_o
);

  uuidg_push_t push;
  logic        push_ready;
  logic        pop_valid;
  uuidg_draw_t pop_data;
  logic        pop;

  // Request handling and word draws.
  uuidg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .reseed_i      (reseed_i),
    .seed_first_i  (seed_first_i),
    .seed_second_i (seed_second_i),
    .push_o        (push),
    .push_ready_i  (push_ready)
  );

  // Decoupling queue.
  uuidg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_i        (pop)
  );

  // Character emission.
  uuidg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_data_i   (pop_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .text_char_o  (text_char_o),
    .char_index_o (char_index_o),
    .last_char_o  (last_char_o)
  );

endmodule

`default_nettype wire

// File: design/uuidg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID generator checker
// Port-level assertions on the output character stream, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module uuidg_checker import uuidg_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] text_char_o,
  input wire logic [5:0] char_index_o,
  input wire logic       last_char_o
);

  // A stalled character holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(text_char_o) && $stable(char_index_o))
    else $error("output character changed while stalled");

  // Characters of one text follow each other without a gap.
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_char_o |=>
      out_valid_o && (char_index_o == $past(char_index_o) + 6'd1))
    else $error("character index did not advance");

  // The last flag marks the final position only.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_char_o == (char_index_o == LastPos)))
    else $error("last flag mismatch");

  // The dashes sit at their positions.
  a_fixed_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((char_index_o == PosDash0) || (char_index_o == PosDash1) ||
                    (char_index_o == PosDash2) || (char_index_o == PosDash3)) |->
      (text_char_o == CharDash))
    else $error("dash missing");

endmodule

bind uuid_v4_text_generator uuidg_checker u_checker (.*);

`default_nettype wire

// File: test/uuid_text_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID text scoreboard
// Tracks the xorshift128+ generator state independently of the design, works
// out the 36 characters that each accepted request must produce and compares
// every character transaction on the output channel with the oldest one due.
// ----------------------------------------------------------------------------

package uuid_text_check_pkg;

  import uuidg_pkg::*;

  // One character of UUID text as it appears on the output channel.
  typedef struct {
    logic [7:0] text_char;
    logic [5:0] char_index;
    logic       last_char;
  } uuid_char_t;

  class uuid_text_scoreboard;

    logic [63:0] state_a;
    logic [63:0] state_b;
    uuid_char_t  chars_due[$];
    int unsigned mismatches;
    int unsigned chars_checked;
    int unsigned requests_seeded;
    int unsigned requests_continued;

    function new();
      state_a            = '0;
      state_b            = '0;
      mismatches         = 0;
      chars_checked      = 0;
      requests_seeded    = 0;
      requests_continued = 0;
    endfunction

    // One xorshift128+ draw: advances the state and returns the sum word.
    function logic [63:0] draw_random_word();
      logic [63:0] s1;
      logic [63:0] s0;
      s1      = state_a;
      s0      = state_b;
      state_a = s0;
      s1      = s1 ^ (s1 << 23);
      state_b = s1 ^ s0 ^ (s1 >> 18) ^ (s0 >> 5);
      return state_b + s0;
    endfunction

    // Lower-case ASCII hex digit of a nibble.
    function logic [7:0] hex_digit(logic [3:0] n);
      return (n < 4'd10) ? 8'h30 + {4'h0, n} : 8'h61 + {4'h0, n} - 8'd10;
    endfunction

    // Works out the whole text of an accepted request and queues it.
    function void note_request(logic reseed, logic [63:0] seed_first,
                               logic [63:0] seed_second);
      logic [63:0] words [2];
      int unsigned nib;
      logic [3:0]  n;
      uuid_char_t  c;
      if (reseed) begin
        state_a = seed_first;
        state_b = seed_second;
        requests_seeded++;
      end else begin
        requests_continued++;
      end
      words[0] = draw_random_word();
      words[1] = draw_random_word();
      nib      = 0;
      for (int pos = 0; pos < UuidLen; pos++) begin
        c.char_index = 6'(pos);
        c.last_char  = (6'(pos) == LastPos);
        if (pos == PosDash0 || pos == PosDash1 || pos == PosDash2 || pos == PosDash3) begin
          c.text_char = CharDash;
        end else if (pos == PosFour) begin
          c.text_char = CharFour;
        end else begin
          // Nibbles run from the bottom of the first word up to the second.
          n = 4'(words[nib / 16] >> (4 * (nib % 16)));
          if (pos == PosVariant) begin
            c.text_char = hex_digit({2'b10, n[1:0]});
          end else begin
            c.text_char = hex_digit(n);
          end
          nib++;
        end
        chars_due.push_back(c);
      end
    endfunction

    // Counts a failure and reports it while the report budget lasts.
    function void report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] MISMATCH: %s", $time, msg);
      end
    endfunction

    // Compares one accepted character transaction with the oldest one due.
    function void check_char(logic [7:0] text_char, logic [5:0] char_index,
                             logic last_char);
      uuid_char_t want;
      chars_checked++;
      if (chars_due.size() == 0) begin
        report_mismatch($sformatf("unexpected char 0x%02h index %0d last %0b",
                                  text_char, char_index, last_char));
        return;
      end
      want = chars_due.pop_front();
      if (text_char !== want.text_char || char_index !== want.char_index ||
          last_char !== want.last_char) begin
        report_mismatch($sformatf(
          "expected char 0x%02h index %0d last %0b, got char 0x%02h index %0d last %0b",
          want.text_char, want.char_index, want.last_char,
          text_char, char_index, last_char));
      end
    endfunction

    function int unsigned pending();
      return chars_due.size();
    endfunction

  endclass

endpackage

// File: test/uuid_v4_text_generator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUID v4 text generator testbench
// Sends seeded and unseeded UUID requests, directed ones first and then a
// random mix, with random idling on both channels, a long output stall and a
// drain pause, and checks every character against the scoreboard.
// ----------------------------------------------------------------------------

module uuid_v4_text_generator_test;

  import uuidg_pkg::*;
  import uuid_text_check_pkg::*;

  localparam int unsigned RandomRequests = 460;
  localparam int unsigned HoldStart      = 2500;
  localparam int unsigned HoldCycles     = 700;
  localparam int unsigned SteadyStart    = 8000;
  localparam int unsigned SteadyEnd      = 11000;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic        reseed        = 1'b0;
  logic [63:0] seed_first    = '0;
  logic [63:0] seed_second   = '0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [7:0]  text_char;
  logic [5:0]  char_index;
  logic        last_char;

  bit                  sender_steady = 1'b0;
  int unsigned         recv_cycles   = 0;
  uuid_text_scoreboard sb;

  uuid_v4_text_generator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .reseed_i     (reseed),
    .seed_first_i (seed_first),
    .seed_second_i(seed_second),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .text_char_o  (text_char),
    .char_index_o (char_index),
    .last_char_o  (last_char)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Receiver: random stalls, one long hold-off and one stretch without stalls.
  always @(negedge clk_i) begin
    recv_cycles <= recv_cycles + 1;
    if (recv_cycles >= HoldStart && recv_cycles < HoldStart + HoldCycles) begin
      out_ready <= 1'b0;
    end else if (recv_cycles >= SteadyStart && recv_cycles < SteadyEnd) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= 6);
    end
  end

  // Every accepted character transaction goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      sb.check_char(text_char, char_index, last_char);
    end
  end

  // Offers one request and returns once it has been accepted.
  task automatic send_request(input logic reseed_v, input logic [63:0] first_v,
                              input logic [63:0] second_v);
    @(negedge clk_i);
    while (!sender_steady && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid    <= 1'b1;
    reseed      <= reseed_v;
    seed_first  <= first_v;
    seed_second <= second_v;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(reseed_v, first_v, second_v);
  endtask

  // Withdraws the request and holds the sender back until every queued
  // character has arrived.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] random_seed();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0:       w = '0;
      1:       w = '1;
      2:       w = 64'(1) << $urandom_range(0, 63);
      default: ;
    endcase
    return w;
  endfunction

  initial begin
    logic        rs;
    logic [63:0] s1;
    logic [63:0] s2;
    sb = new();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: the unseeded generator, zero seeds, extremes and patterns.
    send_request(1'b0, {$urandom, $urandom}, {$urandom, $urandom});
    send_request(1'b0, '0, '0);
    send_request(1'b1, '0, '0);
    send_request(1'b0, '1, '1);
    send_request(1'b1, '1, '1);
    send_request(1'b0, '0, '0);
    send_request(1'b1, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    send_request(1'b1, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_request(1'b1, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000);
    send_request(1'b1, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_request(1'b1, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_request(1'b1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
    send_request(1'b0, 64'hffff_0000_ffff_0000, 64'h0000_ffff_0000_ffff);
    wait_drained();

    // Random part: a mix of reseeds and continued draws.
    for (int i = 0; i < RandomRequests; i++) begin
      if (i == 300) begin
        wait_drained();
      end
      sender_steady = (i >= 150 && i < 260);
      rs = ($urandom_range(0, 3) == 0);
      s1 = random_seed();
      s2 = random_seed();
      send_request(rs, s1, s2);
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("Covered %0d requests: %0d with a fresh seed, %0d continuing the sequence.",
             sb.requests_seeded + sb.requests_continued, sb.requests_seeded,
             sb.requests_continued);
    $display("Checked %0d characters across random stalls and a %0d-cycle output hold-off.",
             sb.chars_checked, HoldCycles);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("uuid_v4_text_generator verification clean");
    end else begin
      $display("uuid_v4_text_generator verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5_000_000;
    $display("uuid_v4_text_generator verification failed");
    $finish;
  end

endmodule
